[sv/assert_macros.svh]
// Assertion macros used by the decoder pixel pipeline.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dxt decoder: property check failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("dxt decoder: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[sv/dxtbd_pkg.sv]
// Types and constants of the DXT block decoder.
// No dependencies; used by every decoder module.
`default_nettype none

package dxtbd_pkg;

   localparam int unsigned REQ_W = 128;
   localparam int unsigned RSP_W = 40;

   typedef enum logic [2:0] {
      MODE_DXT1 = 3'd0,
      MODE_DXT2 = 3'd1,
      MODE_DXT3 = 3'd2,
      MODE_DXT4 = 3'd3,
      MODE_DXT5 = 3'd4,
      MODE_RXGB = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ASRC_OPAQUE   = 2'd0,
      ASRC_EXPLICIT = 2'd1,
      ASRC_INTERP   = 2'd2
   } asrc_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   typedef struct packed {
      logic     transparent;
      logic     premul;
      logic     rxgb;
      asrc_type asrc;
   } ctl_type;

   typedef struct packed {
      logic [63:0] alpha_word;
      logic [31:0] indices;
      rgb_type     c0;
      rgb_type     c1;
      ctl_type     ctl;
   } blk_type;

   typedef struct packed {
      logic    push;
      blk_type blk;
   } qwr_type;

   typedef struct packed {
      logic    empty;
      blk_type blk;
   } qrd_type;

endpackage

`default_nettype wire

[sv/dxtbd_front.sv]
// Front end: mode register, input transfer register and block classification.
// Depends on dxtbd_pkg; feeds dxtbd_queue.
`default_nettype none

module dxtbd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [2:0]                 csr_wr_data,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [dxtbd_pkg::REQ_W-1:0] req_tdata,
   input  wire logic                       q_full,
   output dxtbd_pkg::qwr_type              q_wr
);

   logic [2:0]         mode_ff, mode_in;
   logic               valid_ff, valid_in;
   dxtbd_pkg::blk_type blk_ff, blk_in, blk_cls;
   logic               accept;
   logic [15:0]        color0, color1;

   function automatic dxtbd_pkg::rgb_type widen(input logic [15:0] c);
      dxtbd_pkg::rgb_type w;
      w.r = {c[15:11], 3'b000};
      w.g = {c[10:5], 2'b00};
      w.b = {c[4:0], 3'b000};
      return w;
   endfunction

   assign color0 = req_tdata[79:64];
   assign color1 = req_tdata[95:80];

   always_comb begin
      blk_cls                 = '0;
      blk_cls.alpha_word      = req_tdata[63:0];
      blk_cls.indices         = req_tdata[127:96];
      blk_cls.c0              = widen(color0);
      blk_cls.c1              = widen(color1);
      blk_cls.ctl.asrc        = dxtbd_pkg::ASRC_OPAQUE;
      unique case (dxtbd_pkg::mode_type'(mode_ff))
         dxtbd_pkg::MODE_DXT1: begin
            blk_cls.ctl.transparent = (color0 <= color1);
         end
         dxtbd_pkg::MODE_DXT2: begin
            blk_cls.ctl.premul = 1'b1;
            blk_cls.ctl.asrc   = dxtbd_pkg::ASRC_EXPLICIT;
         end
         dxtbd_pkg::MODE_DXT3: begin
            blk_cls.ctl.asrc = dxtbd_pkg::ASRC_EXPLICIT;
         end
         dxtbd_pkg::MODE_DXT4: begin
            blk_cls.ctl.premul = 1'b1;
            blk_cls.ctl.asrc   = dxtbd_pkg::ASRC_INTERP;
         end
         dxtbd_pkg::MODE_DXT5: begin
            blk_cls.ctl.asrc = dxtbd_pkg::ASRC_INTERP;
         end
         dxtbd_pkg::MODE_RXGB: begin
            blk_cls.ctl.rxgb = 1'b1;
            blk_cls.ctl.asrc = dxtbd_pkg::ASRC_INTERP;
         end
         default: begin
            blk_cls.ctl.asrc = dxtbd_pkg::ASRC_OPAQUE;
         end
      endcase
   end

   assign req_tready = !valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept ? 1'b1 : (valid_ff && q_full);
   assign blk_in     = accept ? blk_cls : blk_ff;
   assign mode_in    = csr_wr_en ? csr_wr_data : mode_ff;

   assign q_wr.push = valid_ff && !q_full;
   assign q_wr.blk  = blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dxtbd_pkg::MODE_DXT1;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

`default_nettype wire

[sv/dxtbd_queue.sv]
// Two-entry block queue between the front end and the pixel pipeline.
// Depends on dxtbd_pkg.
`default_nettype none

module dxtbd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dxtbd_pkg::qwr_type q_wr,
   output logic                    q_full,
   input  wire logic               q_pop,
   output dxtbd_pkg::qrd_type      q_rd
);

   dxtbd_pkg::blk_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign q_full     = (count_ff == 2'd2);
   assign q_rd.empty = (count_ff == 2'd0);
   assign q_rd.blk   = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = q_wr.push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      unique case ({q_wr.push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         mem_ff[wr_ptr_ff] <= q_wr.blk;
      end
   end

endmodule

`default_nettype wire

[sv/dxtbd_back.sv]
// Pixel pipeline: walks the queued block one pixel per cycle, unless stalled, through index
// select, palette/alpha divide, premultiply and output register. Depends on dxtbd_pkg.
`default_nettype none
`include "assert_macros.svh"

module dxtbd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dxtbd_pkg::qrd_type         q_rd,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [dxtbd_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                            rsp_tlast
);

   typedef enum logic [1:0] {
      ADIV_NONE  = 2'd0,
      ADIV_SEVEN = 2'd1,
      ADIV_FIVE  = 2'd2
   } adiv_type;

   typedef struct packed {
      logic [1:0]         col;
      logic [1:0]         row;
      logic               last;
      logic [1:0]         ci;
      dxtbd_pkg::rgb_type c0;
      dxtbd_pkg::rgb_type c1;
      logic               transparent;
      logic               premul;
      logic               rxgb;
      logic [10:0]        anum;
      adiv_type           adiv;
   } s1_type;

   typedef struct packed {
      logic [1:0] col;
      logic [1:0] row;
      logic       last;
      logic       premul;
      logic       rxgb;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } s2_type;

   typedef struct packed {
      logic [1:0]  col;
      logic [1:0]  row;
      logic        last;
      logic        premul;
      logic        rxgb;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [7:0]  a;
   } s3_type;

   typedef struct packed {
      logic [1:0] col;
      logic [1:0] row;
      logic       last;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } out_type;

   function automatic logic [7:0] div3(input logic [8:0] x);
      logic [19:0] m;
      m = {11'b0, x} * 20'd683;
      return m[18:11];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [23:0] m;
      m = {13'b0, x} * 24'd2341;
      return m[21:14];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [23:0] m;
      m = {13'b0, x} * 24'd3277;
      return m[21:14];
   endfunction

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return s[15:8];
   endfunction

   function automatic logic [7:0] pal_chan(input logic [1:0] ci, input logic tr,
                                           input logic [7:0] x0, input logic [7:0] x1);
      logic [7:0] v;
      unique case (ci)
         2'd0: v = x0;
         2'd1: v = x1;
         2'd2: v = tr ? ({1'b0, x0[7:1]} + {1'b0, x1[7:1]})
                      : (div3({x0, 1'b0}) + div3({1'b0, x1}));
         default: v = tr ? 8'd0 : (div3({1'b0, x0}) + div3({x1, 1'b0}));
      endcase
      return v;
   endfunction

   logic        adv, issue;
   logic [3:0]  pix_ff, pix_in;
   logic        v1_ff, v2_ff, v3_ff, out_valid_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   out_type     out_ff, out_in;
   logic [1:0]  ci;
   logic [3:0]  nib;
   logic [5:0]  abase;
   logic [2:0]  acode;
   logic [7:0]  a0, a1;
   logic [3:0]  w0, w1;
   logic [10:0] anum;
   adiv_type    adiv;

   assign adv   = !out_valid_ff || rsp_tready;
   assign issue = !q_rd.empty && adv;
   assign q_pop = issue && (pix_ff == 4'hf);
   assign pix_in = issue ? pix_ff + 4'd1 : pix_ff;

   // pixel select and alpha numerator
   assign ci    = q_rd.blk.indices[{pix_ff, 1'b0} +: 2];
   assign nib   = q_rd.blk.alpha_word[{pix_ff, 2'b00} +: 4];
   assign abase = 6'd16 + {1'b0, pix_ff, 1'b0} + {2'b00, pix_ff};
   assign acode = q_rd.blk.alpha_word[abase +: 3];
   assign a0    = q_rd.blk.alpha_word[7:0];
   assign a1    = q_rd.blk.alpha_word[15:8];

   always_comb begin
      w0   = 4'd0;
      w1   = 4'd0;
      anum = 11'd255;
      adiv = ADIV_NONE;
      unique case (q_rd.blk.ctl.asrc)
         dxtbd_pkg::ASRC_EXPLICIT: begin
            anum = {3'b000, nib, 4'b0000};
         end
         dxtbd_pkg::ASRC_INTERP: begin
            priority if (acode == 3'd0) begin
               anum = {3'b000, a0};
            end else if (acode == 3'd1) begin
               anum = {3'b000, a1};
            end else if (a0 > a1) begin
               w0   = 4'd8 - {1'b0, acode};
               w1   = {1'b0, acode} - 4'd1;
               adiv = ADIV_SEVEN;
            end else if (acode == 3'd6) begin
               anum = 11'd0;
            end else if (acode == 3'd7) begin
               anum = 11'd255;
            end else begin
               w0   = 4'd6 - {1'b0, acode};
               w1   = {1'b0, acode} - 4'd1;
               adiv = ADIV_FIVE;
            end
            if (adiv != ADIV_NONE) begin
               anum = ({7'b0, w0} * {3'b000, a0}) + ({7'b0, w1} * {3'b000, a1});
            end
         end
         default: begin
            anum = (q_rd.blk.ctl.transparent && ci == 2'd3) ? 11'd0 : 11'd255;
         end
      endcase
   end

   always_comb begin
      s1_in.col         = pix_ff[1:0];
      s1_in.row         = pix_ff[3:2];
      s1_in.last        = (pix_ff == 4'hf);
      s1_in.ci          = ci;
      s1_in.c0          = q_rd.blk.c0;
      s1_in.c1          = q_rd.blk.c1;
      s1_in.transparent = q_rd.blk.ctl.transparent;
      s1_in.premul      = q_rd.blk.ctl.premul;
      s1_in.rxgb        = q_rd.blk.ctl.rxgb;
      s1_in.anum        = anum;
      s1_in.adiv        = adiv;
   end

   // palette entry and alpha divide
   always_comb begin
      s2_in.col    = s1_ff.col;
      s2_in.row    = s1_ff.row;
      s2_in.last   = s1_ff.last;
      s2_in.premul = s1_ff.premul;
      s2_in.rxgb   = s1_ff.rxgb;
      s2_in.r = pal_chan(s1_ff.ci, s1_ff.transparent, s1_ff.c0.r, s1_ff.c1.r);
      s2_in.g = pal_chan(s1_ff.ci, s1_ff.transparent, s1_ff.c0.g, s1_ff.c1.g);
      s2_in.b = pal_chan(s1_ff.ci, s1_ff.transparent, s1_ff.c0.b, s1_ff.c1.b);
      unique case (s1_ff.adiv)
         ADIV_SEVEN: s2_in.a = div7(s1_ff.anum);
         ADIV_FIVE:  s2_in.a = div5(s1_ff.anum);
         default:    s2_in.a = s1_ff.anum[7:0];
      endcase
   end

   // premultiply products
   always_comb begin
      s3_in.col    = s2_ff.col;
      s3_in.row    = s2_ff.row;
      s3_in.last   = s2_ff.last;
      s3_in.premul = s2_ff.premul;
      s3_in.rxgb   = s2_ff.rxgb;
      s3_in.a      = s2_ff.a;
      s3_in.r = s2_ff.premul ? ({8'b0, s2_ff.r} * {8'b0, s2_ff.a}) : {8'b0, s2_ff.r};
      s3_in.g = s2_ff.premul ? ({8'b0, s2_ff.g} * {8'b0, s2_ff.a}) : {8'b0, s2_ff.g};
      s3_in.b = s2_ff.premul ? ({8'b0, s2_ff.b} * {8'b0, s2_ff.a}) : {8'b0, s2_ff.b};
   end

   always_comb begin
      out_in.col  = s3_ff.col;
      out_in.row  = s3_ff.row;
      out_in.last = s3_ff.last;
      out_in.r    = s3_ff.premul ? div255(s3_ff.r) : s3_ff.r[7:0];
      out_in.g    = s3_ff.premul ? div255(s3_ff.g) : s3_ff.g[7:0];
      out_in.b    = s3_ff.premul ? div255(s3_ff.b) : s3_ff.b[7:0];
      out_in.a    = s3_ff.a;
      if (s3_ff.rxgb) begin
         out_in.r = s3_ff.a;
         out_in.a = 8'hff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= 4'd0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pix_ff <= pix_in;
         if (adv) begin
            v1_ff        <= issue;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            out_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {4'b0000, out_ff.a, out_ff.b, out_ff.g, out_ff.r,
                        out_ff.row, out_ff.col};

   `ASSERT_CLK(a_last_pos, clock, reset, out_valid_ff && out_ff.last |-> {out_ff.row, out_ff.col} == 4'hf)
   `ASSERT_NEVER(a_pix_no_block, clock, reset, pix_ff != 4'd0 && q_rd.empty)
   `ASSERT_CLK(a_rxgb_alpha, clock, reset, v3_ff && s3_ff.rxgb && adv |=> out_ff.a == 8'hff)

endmodule

`default_nettype wire

[sv/dxt_block_decoder.sv]
// DXT1-5/RXGB 4x4 block decoder, sixteen pixels per block in raster order.
// Each block passes the input transfer register and the queue before the pixel pipeline.
// One pixel per cycle while rsp_tready does not stall the output, set by the single
// pixel pipeline; a two-entry queue lets the next block wait while one drains.
// Reset (synchronous, active high): empties queue and pipeline, mode returns to DXT1.
`default_nettype none

module dxt_block_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_wr_data,   // format_mode
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // alpha_word[63:0], color0[79:64], color1[95:80], color_indices[127:96]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // column[1:0], row[3:2], red[11:4], green[19:12], blue[27:20], alpha[35:28], zero pad
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tlast
);

   dxtbd_pkg::qwr_type q_wr;
   dxtbd_pkg::qrd_type q_rd;
   logic               q_full;
   logic               q_pop;

   dxtbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_wr        (q_wr)
   );

   dxtbd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   dxtbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rd       (q_rd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
